// ===== design/bmh_pkg.sv =====
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 8;
    localparam int DEF_CAPACITY = 255;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                    opcode;
        logic signed [KEY_W-1:0] key_in;
    } cmd_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        status_t                 status;
        logic [COUNT_W-1:0]      count;
    } result_t;

endpackage

// ===== design/binary_min_heap_priority_queue_top.sv =====
// Insert: per level climbed, read the parent (S_UP_RD), then compare and move a larger
// parent down (S_UP_CMP). Extract: load root and last entry (S_EX_LD), then per level
// read both children (S_DN_RD), compare and pull up the smaller (S_DN_CMP).
// A refused insert or extract answers from idle. One operation at a time; busy is
// high while one runs; the one-cycle result strobe cannot be stalled by the receiver.
// Reset clears the count and idles the sequencer; the key store holds no defined data.
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top
// Bounded binary min-heap with the root at slot 1, sifted in a key-store RAM.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_top #(
    parameter int CAPACITY = bmh_pkg::DEF_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bmh_pkg::cmd_t    cmd,
    output logic             done,
    output bmh_pkg::result_t result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = CW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UP_RD  = 6'b000010,
        S_UP_CMP = 6'b000100,
        S_EX_LD  = 6'b001000,
        S_DN_RD  = 6'b010000,
        S_DN_CMP = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [AW-1:0]                    pos_reg, pos_next;
    logic [AW:0]                      child_reg, child_next;
    logic signed [bmh_pkg::KEY_W-1:0] key_reg, key_next;
    logic signed [bmh_pkg::KEY_W-1:0] top_reg, top_next;
    logic                             done_reg, done_next;
    bmh_pkg::result_t                 result_reg, result_next;

    logic                             we;
    logic [AW-1:0]                    waddr;
    logic signed [bmh_pkg::KEY_W-1:0] wdata;
    logic [AW-1:0]                    raddr0, raddr1;
    logic signed [bmh_pkg::KEY_W-1:0] rdata0, rdata1;

    logic [CW-1:0]                    remain;
    logic [AW:0]                      remain_ext;
    logic [AW:0]                      child_inc;
    logic                             pick_right;
    logic signed [bmh_pkg::KEY_W-1:0] sel_key;
    logic [AW:0]                      sel_idx;
    logic [CW+bmh_pkg::COUNT_W-1:0]   cnt_wide;
    logic                             accept;

    bmh_ram #(
        .DEPTH (CAPACITY + 1),
        .AW    (AW)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign accept     = start && (state_reg == S_IDLE);
    assign remain     = cnt_reg - CW'(1);
    assign remain_ext = {1'b0, remain};
    assign child_inc  = child_reg + (AW+1)'(1);
    assign pick_right = (child_reg < remain_ext) && (rdata0 > rdata1);
    assign sel_key    = pick_right ? rdata1 : rdata0;
    assign sel_idx    = pick_right ? child_inc : child_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        child_next  = child_reg;
        key_next    = key_reg;
        top_next    = top_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cnt_wide    = '0;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = key_reg;
        // idle reads fetch the root and the last entry for an extract
        raddr0      = AW'(1);
        raddr1      = cnt_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = cmd.key_in;
                    if (cmd.opcode == bmh_pkg::OP_INSERT)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            cnt_wide            = {{bmh_pkg::COUNT_W{1'b0}}, cnt_reg};
                            done_next           = 1'b1;
                            result_next.key_out = '0;
                            result_next.status  = bmh_pkg::ST_FULL;
                            result_next.count   = cnt_wide[bmh_pkg::COUNT_W-1:0];
                        end
                        else
                        begin
                            pos_next   = cnt_reg[AW-1:0] + AW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            done_next           = 1'b1;
                            result_next.key_out = '0;
                            result_next.status  = bmh_pkg::ST_EMPTY;
                            result_next.count   = '0;
                        end
                        else
                        begin
                            state_next = S_EX_LD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                raddr0 = pos_reg >> 1;
                if (pos_reg > AW'(1))
                begin
                    state_next = S_UP_CMP;
                end
                else
                begin
                    we                  = 1'b1;
                    cnt_next            = cnt_reg + CW'(1);
                    cnt_wide            = {{bmh_pkg::COUNT_W{1'b0}}, cnt_next};
                    done_next           = 1'b1;
                    result_next.key_out = '0;
                    result_next.status  = bmh_pkg::ST_OK;
                    result_next.count   = cnt_wide[bmh_pkg::COUNT_W-1:0];
                    state_next          = S_IDLE;
                end
            end

            S_UP_CMP:
            begin
                we = 1'b1;
                if (key_reg < rdata0)
                begin
                    // move the larger parent down one level
                    wdata      = rdata0;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    cnt_next            = cnt_reg + CW'(1);
                    cnt_wide            = {{bmh_pkg::COUNT_W{1'b0}}, cnt_next};
                    done_next           = 1'b1;
                    result_next.key_out = '0;
                    result_next.status  = bmh_pkg::ST_OK;
                    result_next.count   = cnt_wide[bmh_pkg::COUNT_W-1:0];
                    state_next          = S_IDLE;
                end
            end

            S_EX_LD:
            begin
                top_next   = rdata0;
                key_next   = rdata1;
                pos_next   = AW'(1);
                child_next = (AW+1)'(2);
                state_next = S_DN_RD;
            end

            S_DN_RD:
            begin
                raddr0 = child_reg[AW-1:0];
                raddr1 = child_inc[AW-1:0];
                if (child_reg <= remain_ext)
                begin
                    state_next = S_DN_CMP;
                end
                else
                begin
                    we                  = 1'b1;
                    cnt_next            = remain;
                    cnt_wide            = {{bmh_pkg::COUNT_W{1'b0}}, remain};
                    done_next           = 1'b1;
                    result_next.key_out = top_reg;
                    result_next.status  = bmh_pkg::ST_OK;
                    result_next.count   = cnt_wide[bmh_pkg::COUNT_W-1:0];
                    state_next          = S_IDLE;
                end
            end

            S_DN_CMP:
            begin
                we = 1'b1;
                if (key_reg <= sel_key)
                begin
                    cnt_next            = remain;
                    cnt_wide            = {{bmh_pkg::COUNT_W{1'b0}}, remain};
                    done_next           = 1'b1;
                    result_next.key_out = top_reg;
                    result_next.status  = bmh_pkg::ST_OK;
                    result_next.count   = cnt_wide[bmh_pkg::COUNT_W-1:0];
                    state_next          = S_IDLE;
                end
                else
                begin
                    // pull the smaller child up and descend into its slot
                    wdata      = sel_key;
                    pos_next   = sel_idx[AW-1:0];
                    child_next = {sel_idx[AW-1:0], 1'b0};
                    state_next = S_DN_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        child_reg  <= child_next;
        key_reg    <= key_next;
        top_reg    <= top_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/bmh_ram.sv =====
// ----------------------------------------------------------------------------
// bmh_ram
// Key store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmh_ram #(
    parameter int DEPTH = bmh_pkg::DEF_CAPACITY + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic signed [bmh_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0]                    raddr0,
    input  logic [AW-1:0]                    raddr1,
    output logic signed [bmh_pkg::KEY_W-1:0] rdata0,
    output logic signed [bmh_pkg::KEY_W-1:0] rdata1
);

    logic signed [bmh_pkg::KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== design/bmh_checker.sv =====
// ----------------------------------------------------------------------------
// bmh_checker
// Port-level checks on the heap queue: beat completion and refusal results.
// ----------------------------------------------------------------------------
module bmh_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bmh_pkg::result_t result
);

    // every accepted beat either answers at once or engages the sequencer
    a_accept_progress : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted beat neither answered nor started");

    // finishing an operation always posts its result
    a_finish_posts : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("operation ended without a result beat");

    // a result beat is never shown while an operation still runs
    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == bmh_pkg::ST_EMPTY) |->
            (result.count == '0 && result.key_out == '0))
        else $error("empty extract returned a key or a nonzero count");

    a_full_result : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == bmh_pkg::ST_FULL) |-> (result.key_out == '0))
        else $error("refused insert returned a key");

endmodule

bind binary_min_heap_priority_queue_top bmh_checker u_bmh_checker (.*);
